@@ rtl/rpd_pkg.sv @@
// ----------------------------------------------------------------------------
// rpd_pkg
// Types and character constants shared by the remote serial protocol
// packet deframer modules.
// ----------------------------------------------------------------------------
package rpd_pkg;

    // framing characters
    localparam logic [7:0] CH_BREAK = 8'h03;
    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END   = 8'h23;

    // acknowledge characters
    localparam logic [7:0] ACK_OK   = 8'h2B;
    localparam logic [7:0] ACK_BAD  = 8'h2D;
    localparam logic [7:0] ACK_NONE = 8'h00;

    // result kind codes
    typedef enum logic [2:0] {
        K_PAYLOAD  = 3'd0,
        K_OK       = 3'd1,
        K_BAD      = 3'd2,
        K_BREAK    = 3'd3,
        K_IGNORED  = 3'd4,
        K_OVERFLOW = 3'd5
    } t_kind;

    // deframer phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DIGIT1  = 2'd2,
        PH_DIGIT2  = 2'd3
    } t_phase;

    // classified byte, front to back
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       is_break;
        logic       is_start;
        logic       is_end;
        logic       hex_ok;
        logic [3:0] nibble;
    } t_class;

    // queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

endpackage

@@ rtl/rsp_packet_deframer_core.sv @@
// ----------------------------------------------------------------------------
// rsp_packet_deframer_core
// Receive-side deframer of a debugger remote serial link: reports breaks,
// ignored bytes, payload bytes, overflows and checked packet ends with ack character.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          fields
//  rx        in         i_valid / o_stall  i_rx_byte
//  result    out        o_valid / i_stall  o_kind, o_data, o_ack_char,
//                                          o_payload_length
//
//  one byte per cycle sustained unless the result side stalls; results pass the queue and the output register
//  the phase machine in the back part holds the only per-byte loop
//  o_stall rises only when the two-entry queue is full
//  a stalled result waits in the output register while the queue fills
//  synchronous active-low reset returns to idle with an empty queue
// ----------------------------------------------------------------------------
module rsp_packet_deframer_core #(
    parameter int MAX_PACKET_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data,
    output logic [7:0]  o_ack_char,
    output logic [11:0] o_payload_length
);
    import rpd_pkg::*;

    t_class w_class;
    t_class w_head;
    logic   w_full;
    logic   w_push;
    logic   w_pop;
    logic   w_head_valid;

    // byte classification
    rpd_front u_front (
        .i_rx_byte (i_rx_byte),
        .o_class   (w_class)
    );

    assign o_stall = w_full;
    assign w_push  = i_valid && !w_full;

    // decoupling queue
    rpd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_class),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_nonempty  (w_head_valid)
    );

    // packet phase machine and result register
    rpd_back #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (w_head_valid),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_data           (o_data),
        .o_ack_char       (o_ack_char),
        .o_payload_length (o_payload_length)
    );

    // ack character matches the result kind
    a_ack_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_ack_char == ACK_OK) == (o_kind == K_OK)) &&
                    ((o_ack_char == ACK_BAD) == (o_kind == K_BAD)))
        else $error("ack character does not match result kind");

    // length is zero except on packet end
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind != K_OK) && (o_kind != K_BAD)) |-> (o_payload_length == 12'd0))
        else $error("payload length on a non packet-end result");

    // a pop only happens with a queued byte
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("pop from an empty queue");

endmodule

@@ rtl/rpd_front.sv @@
// ----------------------------------------------------------------------------
// rpd_front
// Classifies each received byte: framing characters and hex digit value.
// ----------------------------------------------------------------------------
module rpd_front (
    input  logic [7:0]     i_rx_byte,
    output rpd_pkg::t_class o_class
);
    import rpd_pkg::*;

    logic       w_dec;
    logic       w_lower;
    logic       w_upper;
    logic [3:0] w_nib;

    // hex digit decode, either case
    always_comb begin
        w_dec   = (i_rx_byte >= 8'h30) && (i_rx_byte <= 8'h39);
        w_lower = (i_rx_byte >= 8'h61) && (i_rx_byte <= 8'h66);
        w_upper = (i_rx_byte >= 8'h41) && (i_rx_byte <= 8'h46);
        if (w_dec) begin
            w_nib = i_rx_byte[3:0];
        end else if (w_lower || w_upper) begin
            w_nib = i_rx_byte[3:0] + 4'd9;
        end else begin
            w_nib = 4'd0;
        end
    end

    // classified byte
    always_comb begin
        o_class.rx_byte  = i_rx_byte;
        o_class.is_break = (i_rx_byte == CH_BREAK);
        o_class.is_start = (i_rx_byte == CH_START);
        o_class.is_end   = (i_rx_byte == CH_END);
        o_class.hex_ok   = w_dec || w_lower || w_upper;
        o_class.nibble   = w_nib;
    end

endmodule

@@ rtl/rpd_queue.sv @@
// ----------------------------------------------------------------------------
// rpd_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module rpd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rpd_pkg::t_class i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output rpd_pkg::t_class o_head,
    output logic            o_nonempty
);
    import rpd_pkg::*;

    t_class              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   n_count;

    // pointers and fill count
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head     = r_mem[r_rd_ptr];
    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);

endmodule

@@ rtl/rpd_back.sv @@
// ----------------------------------------------------------------------------
// rpd_back
// Packet phase machine: running checksum, length count, checksum compare,
// and the result register on the output channel.
// ----------------------------------------------------------------------------
module rpd_back #(
    parameter int MAX_PACKET_BYTES = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  rpd_pkg::t_class i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_data,
    output logic [7:0]      o_ack_char,
    output logic [11:0]     o_payload_length
);
    import rpd_pkg::*;

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_PACKET_BYTES - 4);

    t_phase             r_phase;
    t_phase             n_phase;
    logic [7:0]         r_sum;
    logic [7:0]         n_sum;
    logic [3:0]         r_high;
    logic [3:0]         n_high;
    logic               r_digit_bad;
    logic               n_digit_bad;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    logic               r_out_valid;
    t_kind              r_kind;
    logic [7:0]         r_data;
    logic [7:0]         r_ack;
    logic [11:0]        r_len;

    logic               w_emit;
    t_kind              w_kind;
    logic [7:0]         w_data;
    logic [7:0]         w_ack;
    logic [11:0]        w_len;
    logic [7:0]         w_rx_sum;
    logic               w_advance;
    logic [CNT_W+11:0]  w_len_ext;

    // received checksum from both digits
    assign w_rx_sum  = {r_high, (i_head.hex_ok ? i_head.nibble : 4'd0)};
    assign w_len_ext = {12'd0, r_count};

    // take the head when its result, if any, has a free slot
    assign w_advance = i_head_valid && (!w_emit || !r_out_valid || !i_stall);
    assign o_pop     = w_advance;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_high      = r_high;
        n_digit_bad = r_digit_bad;
        n_count     = r_count;
        case (r_phase)
            PH_IDLE: begin
                if (!i_head.is_break && i_head.is_start) begin
                    n_phase = PH_PAYLOAD;
                    n_sum   = '0;
                    n_count = '0;
                end
            end
            PH_PAYLOAD: begin
                if (i_head.is_end) begin
                    n_phase = PH_DIGIT1;
                end else if (r_count >= LIMIT) begin
                    n_phase     = PH_IDLE;
                    n_sum       = '0;
                    n_high      = '0;
                    n_digit_bad = 1'b0;
                    n_count     = '0;
                end else begin
                    n_count = r_count + 1'b1;
                    n_sum   = r_sum + i_head.rx_byte;
                end
            end
            PH_DIGIT1: begin
                n_phase     = PH_DIGIT2;
                n_high      = i_head.hex_ok ? i_head.nibble : 4'd0;
                n_digit_bad = !i_head.hex_ok;
            end
            PH_DIGIT2: begin
                n_phase     = PH_IDLE;
                n_sum       = '0;
                n_high      = '0;
                n_digit_bad = 1'b0;
                n_count     = '0;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // result for the head byte
    always_comb begin
        w_emit = 1'b0;
        w_kind = K_PAYLOAD;
        w_data = i_head.rx_byte;
        w_ack  = ACK_NONE;
        w_len  = '0;
        case (r_phase)
            PH_IDLE: begin
                if (i_head.is_break) begin
                    w_emit = 1'b1;
                    w_kind = K_BREAK;
                end else if (!i_head.is_start) begin
                    w_emit = 1'b1;
                    w_kind = K_IGNORED;
                end
            end
            PH_PAYLOAD: begin
                if (!i_head.is_end) begin
                    w_emit = 1'b1;
                    w_kind = (r_count >= LIMIT) ? K_OVERFLOW : K_PAYLOAD;
                end
            end
            PH_DIGIT1: begin
                w_emit = 1'b0;
            end
            PH_DIGIT2: begin
                w_emit = 1'b1;
                w_data = w_rx_sum;
                w_len  = w_len_ext[11:0];
                if (r_digit_bad || !i_head.hex_ok || (w_rx_sum != r_sum)) begin
                    w_kind = K_BAD;
                    w_ack  = ACK_BAD;
                end else begin
                    w_kind = K_OK;
                    w_ack  = ACK_OK;
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // phase and packet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_sum       <= '0;
            r_high      <= '0;
            r_digit_bad <= 1'b0;
            r_count     <= '0;
        end else if (w_advance) begin
            r_phase     <= n_phase;
            r_sum       <= n_sum;
            r_high      <= n_high;
            r_digit_bad <= n_digit_bad;
            r_count     <= n_count;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_kind <= w_kind;
            r_data <= w_data;
            r_ack  <= w_ack;
            r_len  <= w_len;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_kind;
    assign o_data           = r_data;
    assign o_ack_char       = r_ack;
    assign o_payload_length = r_len;

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rsp_packet_deframer_core. A short table of directed
// requests covers framing, breaks, checksum cases in both letter cases and
// non-hex digits. Random packets and line noise follow. Every result is
// checked in order against the table or a cycle-free model of the
// deframer. Both sides idle at random, and the result side holds off long
// enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
    import rpd_pkg::*;

    localparam int MAX_PACKET_BYTES = 4096;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD        = 80;
    localparam int REPORT_LIMIT     = 10;

    // hex digit characters
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    // how a random packet closes
    typedef enum int {
        CK_GOOD,
        CK_WRONG,
        CK_BAD_HI,
        CK_BAD_LO
    } t_check;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [7:0]  ack;
        logic [11:0] len;
    } t_result;

    typedef struct {
        logic [7:0] rx;
        bit         typed;
        bit         has;
        t_result    res;
    } t_row;

    localparam t_result NO_RESULT = '{kind: K_PAYLOAD, data: 8'h00, ack: ACK_NONE,
                                      len: 12'd0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_data;
    logic [7:0]  o_ack_char;
    logic [11:0] o_payload_length;

    // deframer model state
    t_phase      fr_phase;
    logic [7:0]  fr_sum;
    logic [3:0]  fr_hi;
    bit          fr_hi_bad;
    logic [12:0] fr_count;

    t_result     awaited_results[$];
    t_row        directed_rows[$];
    int          mismatches = 0;
    int          sent_items = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          holds_requested = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    rsp_packet_deframer_core #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_data           (o_data),
        .o_ack_char       (o_ack_char),
        .o_payload_length (o_payload_length)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // hex digit value, ok low for anything else
    function automatic logic [3:0] hex_nibble(input logic [7:0] c, output bit ok);
        ok = 1'b1;
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9) return 4'(c - CH_DIGIT0);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) return 4'(c - CH_LOWER_A + 10);
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) return 4'(c - CH_UPPER_A + 10);
        ok = 1'b0;
        return 4'd0;
    endfunction

    function automatic void clear_frame();
        fr_phase  = PH_IDLE;
        fr_sum    = 8'h00;
        fr_hi     = 4'd0;
        fr_hi_bad = 1'b0;
        fr_count  = 13'd0;
    endfunction

    // advance the deframer model by one byte, returns 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] rx, output t_result res);
        logic [3:0] nib;
        bit         ok;
        bit         bad;
        logic [7:0] rcv;
        res = '{kind: K_PAYLOAD, data: rx, ack: ACK_NONE, len: 12'd0};
        case (fr_phase)
            PH_IDLE: begin
                if (rx == CH_BREAK) begin
                    res.kind = K_BREAK;
                    return 1'b1;
                end
                if (rx == CH_START) begin
                    fr_sum   = 8'h00;
                    fr_count = 13'd0;
                    fr_phase = PH_PAYLOAD;
                    return 1'b0;
                end
                res.kind = K_IGNORED;
                return 1'b1;
            end
            PH_PAYLOAD: begin
                if (rx == CH_END) begin
                    fr_phase = PH_DIGIT1;
                    return 1'b0;
                end
                if (fr_count >= 13'(MAX_PACKET_BYTES - 4)) begin
                    res.kind = K_OVERFLOW;
                    clear_frame();
                    return 1'b1;
                end
                fr_count = fr_count + 13'd1;
                fr_sum   = fr_sum + rx;
                return 1'b1;
            end
            PH_DIGIT1: begin
                nib       = hex_nibble(rx, ok);
                fr_hi_bad = !ok;
                fr_hi     = nib;
                fr_phase  = PH_DIGIT2;
                return 1'b0;
            end
            default: begin
                nib = hex_nibble(rx, ok);
                rcv = {fr_hi, nib};
                bad = fr_hi_bad || !ok || (rcv != fr_sum);
                res.kind = bad ? K_BAD : K_OK;
                res.data = rcv;
                res.ack  = bad ? ACK_BAD : ACK_OK;
                res.len  = fr_count[11:0];
                clear_frame();
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // one request on the rx side; typed rows replace the modeled result
    task automatic send_byte(input logic [7:0] rx, input bit typed, input bit typed_has,
                             input t_result typed_res);
        bit      produced;
        t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        produced = deframe_byte(rx, res);
        if (typed) begin
            produced = typed_has;
            res      = typed_res;
        end
        if (produced) awaited_results.insert(awaited_results.size(), res);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send(input logic [7:0] rx);
        send_byte(rx, 1'b0, 1'b0, NO_RESULT);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return CH_DIGIT0 + 8'(n);
        return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        bit         ok;
        do begin
            c = 8'($urandom_range(255));
            void'(hex_nibble(c, ok));
        end while (ok);
        return c;
    endfunction

    // a framed packet with random payload and a chosen checksum ending
    task automatic send_packet(input int len, input t_check mode);
        logic [7:0] sum;
        logic [7:0] pb;
        logic [7:0] cs;
        sum = 8'h00;
        send(CH_START);
        for (int i = 0; i < len; i++) begin
            do pb = 8'($urandom_range(255)); while (pb == CH_END);
            sum = sum + pb;
            send(pb);
        end
        send(CH_END);
        case (mode)
            CK_GOOD, CK_WRONG: begin
                cs = (mode == CK_GOOD) ? sum : sum ^ 8'($urandom_range(1, 255));
                send(hex_char(cs[7:4]));
                send(hex_char(cs[3:0]));
            end
            CK_BAD_HI: begin
                send(non_hex_char());
                send(hex_char(sum[3:0]));
            end
            default: begin
                send(hex_char(sum[7:4]));
                send(non_hex_char());
            end
        endcase
    endtask

    // random traffic until n requests have gone in
    task automatic run_random(input int n);
        int     start;
        int     r;
        int     len;
        t_check mode;
        start = sent_items;
        while (sent_items - start < n) begin
            r = $urandom_range(99);
            if (r < 70) begin
                len = ($urandom_range(99) < 80) ? $urandom_range(16) : $urandom_range(17, 200);
                r = $urandom_range(99);
                mode = (r < 70) ? CK_GOOD : (r < 85) ? CK_WRONG : (r < 93) ? CK_BAD_HI
                                                                           : CK_BAD_LO;
                send_packet(len, mode);
            end else if (r < 85) begin
                repeat ($urandom_range(1, 4)) send(8'($urandom_range(255)));
            end else if (r < 93) begin
                send(CH_BREAK);
            end else begin
                // truncated frame with arbitrary checksum bytes
                send(CH_START);
                repeat ($urandom_range(3)) send(8'($urandom_range(255)));
                send(CH_END);
                send(8'($urandom_range(255)));
                send(8'($urandom_range(255)));
            end
        end
    endtask

    function automatic void add_row(input logic [7:0] rx, input bit typed, input bit has,
                                    input t_kind kind, input logic [7:0] data,
                                    input logic [7:0] ack, input logic [11:0] len);
        t_row row;
        row.rx    = rx;
        row.typed = typed;
        row.has   = has;
        row.res   = '{kind: kind, data: data, ack: ack, len: len};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // result side stall, with long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_served < holds_requested) begin
            i_stall      <= 1'b1;
            hold_left    <= LONG_HOLD - 1;
            holds_served <= holds_served + 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result: kind %0d data %02h ack %02h len %0d",
                                        o_kind, o_data, o_ack_char, o_payload_length));
            end else begin
                want = awaited_results.pop_front();
                if (o_kind !== want.kind || o_data !== want.data ||
                    o_ack_char !== want.ack || o_payload_length !== want.len) begin
                    note_mismatch($sformatf({"result differs: kind %0d/%0d data %02h/%02h ",
                                             "ack %02h/%02h len %0d/%0d (expected/actual)"},
                                            want.kind, o_kind, want.data, o_data,
                                            want.ack, o_ack_char, want.len,
                                            o_payload_length));
                end
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("rsp_packet_deframer_core: mismatch");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        clear_frame();
        // idle phase characters
        add_row(CH_BREAK, 1, 1, K_BREAK,   CH_BREAK, ACK_NONE, 12'd0);
        add_row(8'h00,    1, 1, K_IGNORED, 8'h00,    ACK_NONE, 12'd0);
        add_row(8'hFF,    1, 1, K_IGNORED, 8'hFF,    ACK_NONE, 12'd0);
        add_row(CH_END,   1, 1, K_IGNORED, CH_END,   ACK_NONE, 12'd0);
        // empty packet, checksum 00
        add_row(CH_START,  1, 0, K_PAYLOAD, 8'h00, ACK_NONE, 12'd0);
        add_row(CH_END,    1, 0, K_PAYLOAD, 8'h00, ACK_NONE, 12'd0);
        add_row(CH_DIGIT0, 1, 0, K_PAYLOAD, 8'h00, ACK_NONE, 12'd0);
        add_row(CH_DIGIT0, 1, 1, K_OK,      8'h00, ACK_OK,   12'd0);
        // break and start characters inside a packet, lower-case checksum
        add_row(CH_START, 1, 0, K_PAYLOAD, 8'h00,    ACK_NONE, 12'd0);
        add_row(CH_BREAK, 1, 1, K_PAYLOAD, CH_BREAK, ACK_NONE, 12'd0);
        add_row(CH_START, 1, 1, K_PAYLOAD, CH_START, ACK_NONE, 12'd0);
        add_row(8'h7A,    1, 1, K_PAYLOAD, 8'h7A,    ACK_NONE, 12'd0);
        add_row(CH_END,   1, 0, K_PAYLOAD, 8'h00,    ACK_NONE, 12'd0);
        add_row(8'h61,    1, 0, K_PAYLOAD, 8'h00,    ACK_NONE, 12'd0);
        add_row(8'h31,    0, 0, K_PAYLOAD, 8'h00,    ACK_NONE, 12'd0);
        // upper-case checksum that is off by one
        add_row(CH_START, 1, 0, K_PAYLOAD, 8'h00, ACK_NONE, 12'd0);
        add_row(8'hFF,    1, 1, K_PAYLOAD, 8'hFF, ACK_NONE, 12'd0);
        add_row(CH_END,   1, 0, K_PAYLOAD, 8'h00, ACK_NONE, 12'd0);
        add_row(8'h46,    1, 0, K_PAYLOAD, 8'h00, ACK_NONE, 12'd0);
        add_row(8'h45,    0, 0, K_PAYLOAD, 8'h00, ACK_NONE, 12'd0);
        // non-hex first digit fails even though the value matches
        add_row(CH_START,  1, 0, K_PAYLOAD, 8'h00, ACK_NONE, 12'd0);
        add_row(CH_END,    1, 0, K_PAYLOAD, 8'h00, ACK_NONE, 12'd0);
        add_row(8'h67,     1, 0, K_PAYLOAD, 8'h00, ACK_NONE, 12'd0);
        add_row(CH_DIGIT0, 1, 1, K_BAD,     8'h00, ACK_BAD,  12'd0);
        // non-hex second digit
        add_row(CH_START,  1, 0, K_PAYLOAD, 8'h00, ACK_NONE, 12'd0);
        add_row(CH_END,    1, 0, K_PAYLOAD, 8'h00, ACK_NONE, 12'd0);
        add_row(CH_DIGIT0, 1, 0, K_PAYLOAD, 8'h00, ACK_NONE, 12'd0);
        add_row(8'h2F,     1, 1, K_BAD,     8'h00, ACK_BAD,  12'd0);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sender idles less than receiver
        send_idle_pct = 35;
        recv_idle_pct = 66;
        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].has,
                      directed_rows[i].res);
        end
        run_random(240);

        // receiver idles less than sender
        send_idle_pct = 66;
        recv_idle_pct = 35;
        run_random(240);

        // full rate with long hold-offs on the result side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holds_requested = holds_requested + 1;
        run_random(120);
        holds_requested = holds_requested + 1;
        run_random(120);

        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("rsp_packet_deframer_core: match");
        end else begin
            $display("rsp_packet_deframer_core: mismatch");
        end
        $finish;
    end

endmodule
